/* hw/rtl/blr_pkg.sv */
// ----------------------------------------------------------------------------
// blr_pkg
// Shared types and constants of the line raster unit: field widths, item
// modes and the sequencer states.
// ----------------------------------------------------------------------------
package blr_pkg;

  localparam int unsigned FRAME_WIDTH  = 256;
  localparam int unsigned FRAME_HEIGHT = 256;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned COUNT_W = 13;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic [COUNT_W-1:0]        count_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic {
    MODE_DRAW = 1'b0,
    MODE_READ = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_READ,
    ST_DONE
  } state_e;

endpackage

/* hw/rtl/blr_req_if.sv */
// ----------------------------------------------------------------------------
// blr_req_if
// Request channel: one draw or read item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface blr_req_if import blr_pkg::*; ();

  logic   valid;
  logic   ready;
  logic   mode;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  color_t color;

  modport source (
    output valid, mode, start_x, start_y, end_x, end_y, color,
    input  ready
  );

  modport sink (
    input  valid, mode, start_x, start_y, end_x, end_y, color,
    output ready
  );

endinterface

/* hw/rtl/blr_rsp_if.sv */
// ----------------------------------------------------------------------------
// blr_rsp_if
// Response channel: one result item per request item.
// ----------------------------------------------------------------------------
interface blr_rsp_if import blr_pkg::*; ();

  logic   valid;
  logic   ready;
  count_t pixels_written;
  color_t read_color;

  modport source (
    output valid, pixels_written, read_color,
    input  ready
  );

  modport sink (
    input  valid, pixels_written, read_color,
    output ready
  );

endinterface

/* hw/rtl/bresenham_line_raster_unit.sv */
// ----------------------------------------------------------------------------
// bresenham_line_raster_unit
// Line rasterizer over a WIDTH x HEIGHT frame store of 24-bit colors.
//
//   channel | dir | payload                                   | handshake
//   req_i   | in  | mode, start_x, start_y, end_x, end_y, color | valid/ready
//   rsp_o   | out | pixels_written, read_color                | valid/ready
//
// A draw item walks at most max(|dx|, |dy|) + 1 points, fewer on an early
// stop, one point per cycle through the single write port of the frame
// store. After reset a clearing pass writes zero to every entry, one per
// cycle (WIDTH*HEIGHT entries, 65536 at defaults); req_i.ready stays low
// meanwhile. A stalled result holds in the output register; the unit
// returns to idle and takes the next item once the result is loaded there.
// ----------------------------------------------------------------------------
module bresenham_line_raster_unit import blr_pkg::*; #(
  parameter int unsigned WIDTH  = FRAME_WIDTH,
  parameter int unsigned HEIGHT = FRAME_HEIGHT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  blr_req_if.sink   req_i,
  blr_rsp_if.source rsp_o
);

  localparam int unsigned DEPTH = WIDTH * HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XW    = $clog2(WIDTH);
  localparam int unsigned YW    = $clog2(HEIGHT);
  localparam int unsigned CW    = COORD_W + 1;
  localparam int unsigned EW    = COORD_W + 3;

  localparam logic signed [CW-1:0] WIDTH_S    = CW'(WIDTH);
  localparam logic signed [CW-1:0] HEIGHT_S   = CW'(HEIGHT);
  localparam logic [AW-1:0]        LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [AW-1:0]        ROW_STRIDE = AW'(WIDTH);
  localparam logic signed [EW-1:0] ERR_ZERO   = '0;

  typedef logic signed [CW-1:0] wcoord_t;
  typedef logic signed [EW-1:0] err_t;
  typedef logic [COORD_W:0]     delta_t;

  state_e  state_q, state_d;
  mode_e   mode_q;
  coord_t  x_q, y_q, ex_q, ey_q;
  delta_t  dx_q, dy_q;
  logic    sx_neg_q, sy_neg_q;
  err_t    err_q;
  color_t  color_q;
  count_t  count_q;
  logic [AW-1:0] clr_q;

  logic    rsp_valid_q;
  count_t  rsp_count_q;
  color_t  rsp_color_q;

  color_t  frame_mem_q [DEPTH];
  color_t  rdata_q;

  // start-of-line setup
  wcoord_t diff_x, diff_y;
  delta_t  adx, ady;
  logic    sx_neg, sy_neg;
  err_t    err_init;

  // walk step
  wcoord_t xw, yw, exw, eyw;
  logic    in_frame, walk_done;
  logic    c_x, c_y;
  err_t    dx_e, dy_e, err_nxt;
  coord_t  x_nxt, y_nxt;
  logic [AW-1:0] pix_addr;

  // control
  logic          req_acc, rsp_free, rsp_load, rd_en;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  color_t        mem_wdata;

  always_comb begin
    diff_x   = CW'(req_i.end_x) - CW'(req_i.start_x);
    diff_y   = CW'(req_i.end_y) - CW'(req_i.start_y);
    adx      = diff_x[CW-1] ? delta_t'(-diff_x) : delta_t'(diff_x);
    ady      = diff_y[CW-1] ? delta_t'(-diff_y) : delta_t'(diff_y);
    sx_neg   = diff_x[CW-1] || (diff_x == '0);
    sy_neg   = diff_y[CW-1] || (diff_y == '0);
    err_init = (adx > ady) ? $signed(EW'(adx >> 1)) : -$signed(EW'(ady >> 1));
  end

  always_comb begin
    xw  = CW'(x_q);
    yw  = CW'(y_q);
    exw = CW'(ex_q);
    eyw = CW'(ey_q);

    in_frame  = !x_q[COORD_W-1] && (xw < WIDTH_S) && !y_q[COORD_W-1] && (yw < HEIGHT_S);
    walk_done = ((x_q == ex_q) && (y_q == ey_q))
             || (x_q[COORD_W-1] && ex_q[COORD_W-1])
             || (y_q[COORD_W-1] && ey_q[COORD_W-1])
             || ((xw > WIDTH_S) && (exw > WIDTH_S))
             || ((yw > HEIGHT_S) && (eyw > HEIGHT_S));

    dx_e    = $signed(EW'(dx_q));
    dy_e    = $signed(EW'(dy_q));
    c_x     = err_q > -dx_e;
    c_y     = err_q < dy_e;
    err_nxt = err_q - (c_x ? dy_e : ERR_ZERO) + (c_y ? dx_e : ERR_ZERO);
    x_nxt   = c_x ? (sx_neg_q ? x_q - coord_t'(1) : x_q + coord_t'(1)) : x_q;
    y_nxt   = c_y ? (sy_neg_q ? y_q - coord_t'(1) : y_q + coord_t'(1)) : y_q;

    pix_addr = AW'(AW'(y_q[YW-1:0]) * ROW_STRIDE) + AW'(x_q[XW-1:0]);
  end

  assign rsp_free = !rsp_valid_q || rsp_o.ready;
  assign req_acc  = req_i.valid && req_i.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_ADDR) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_i.valid) state_d = (req_i.mode == MODE_READ) ? ST_READ : ST_DRAW;
      end
      ST_DRAW: begin
        if (walk_done) state_d = ST_DONE;
      end
      ST_READ: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = pix_addr;
    mem_wdata   = color_q;
    rd_en       = 1'b0;
    rsp_load    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        req_i.ready = 1'b1;
      end
      ST_DRAW: begin
        mem_we = in_frame;
      end
      ST_READ: begin
        rd_en = in_frame;
      end
      ST_DONE: begin
        rsp_load = rsp_free;
      end
      default: begin
        req_i.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      mode_q   <= mode_e'(req_i.mode);
      x_q      <= req_i.start_x;
      y_q      <= req_i.start_y;
      ex_q     <= req_i.end_x;
      ey_q     <= req_i.end_y;
      dx_q     <= adx;
      dy_q     <= ady;
      sx_neg_q <= sx_neg;
      sy_neg_q <= sy_neg;
      err_q    <= err_init;
      color_q  <= req_i.color;
      count_q  <= '0;
    end else if (state_q == ST_DRAW) begin
      if (in_frame && (count_q != COUNT_MAX)) count_q <= count_q + count_t'(1);
      if (!walk_done) begin
        x_q   <= x_nxt;
        y_q   <= y_nxt;
        err_q <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_count_q <= count_q;
      rsp_color_q <= ((mode_q == MODE_READ) && in_frame) ? rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) frame_mem_q[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= frame_mem_q[pix_addr];
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.pixels_written = rsp_count_q;
  assign rsp_o.read_color     = rsp_color_q;

  a_no_rsp_in_clear : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !rsp_valid_q
  ) else $error("result presented during clearing pass");

  a_read_no_count : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && (mode_q == MODE_READ)) |-> (count_q == '0)
  ) else $error("read item carries a pixel count");

  a_count_monotonic : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW) |=> (count_q >= $past(count_q))
  ) else $error("pixel count went backwards during a walk");

endmodule
